@@ rtl/idll_pkg.sv @@
// Shared types, codes and defaults for the indexed doubly linked list cursor.
package idll_pkg;

	localparam int NODES_DEF        = 16;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int STATUS_W         = 3;

	typedef enum logic [2:0] {
		OP_INS_BEFORE = 3'd0,
		OP_INS_AFTER  = 3'd1,
		OP_REMOVE     = 3'd2,
		OP_FORWARD    = 3'd3,
		OP_BACKWARD   = 3'd4,
		OP_TO_HEAD    = 3'd5,
		OP_TO_TAIL    = 3'd6,
		OP_READ       = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SUCCESS  = 3'd0,
		ST_FULL     = 3'd1,
		ST_END      = 3'd2,
		ST_START    = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_NO_CUR   = 3'd5
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic accept;   // latch request, fetch links and payload at the cursor
		logic exec;     // finish a non-insert request
		logic full;     // finish an insert that found no room
		logic search;   // examine one slot for a free entry
		logic link1;    // write the new node's own links
		logic link2;    // patch neighbors and pointers, finish the insert
	} idll_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_ins;   // latched request is an insert
		logic room;     // node count below the limit
		logic hit;      // slot under the search pointer is free
		logic last;     // search is on its final slot
	} idll_flags_t;

endpackage

@@ rtl/idll_dpath.sv @@
// Datapath: link and payload memories, list pointers, free-slot search, result register.
module idll_dpath import idll_pkg::*; #(
	parameter int NODES        = NODES_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
	localparam int IW          = $clog2(NODES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [IW-1:0]           cfg_wdata,
	input  logic [2:0]              op,
	input  logic [PAYLOAD_BITS-1:0] data_in,
	input  idll_cmd_t               cmd,
	output idll_flags_t             flags,
	output logic [STATUS_W-1:0]     status,
	output logic [IW-1:0]           node_index,
	output logic [PAYLOAD_BITS-1:0] data_out,
	output logic                    done
);

	localparam logic [IW-1:0] ZERO_W  = '0;
	localparam logic [IW-1:0] ONE_W   = IW'(1);
	localparam logic [IW-1:0] NODES_W = IW'(NODES);

	logic [IW-1:0]           nxt_mem [NODES+1];
	logic [IW-1:0]           prv_mem [NODES+1];
	logic [PAYLOAD_BITS-1:0] pay_mem [NODES+1];

	logic [IW-1:0]           nxt_rd_q, prv_rd_q;
	logic [PAYLOAD_BITS-1:0] pay_rd_q;

	logic [IW-1:0] head_q, tail_q, cur_q, used_q, sptr_q, limit_q, nw_q, cnt_q;
	logic [NODES:0] valid_q;
	op_t            op_q;
	logic [PAYLOAD_BITS-1:0] data_q;

	logic [STATUS_W-1:0]     status_q;
	logic [IW-1:0]           idx_q;
	logic [PAYLOAD_BITS-1:0] dout_q;
	logic                    done_q;

	logic [IW-1:0] lim, sptr_adv, c, p, n;
	logic          ins_front;
	logic          nxt_we, prv_we;
	logic [IW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;
	logic [IW-1:0] cur_x;
	status_t       st_x;
	logic [IW-1:0] idx_x;
	logic [PAYLOAD_BITS-1:0] dout_x;
	logic          in_ins;

	assign c         = cur_q;
	assign p         = prv_rd_q;
	assign n         = nxt_rd_q;
	assign ins_front = (op_q == OP_INS_BEFORE);
	assign in_ins    = (op_t'(op) == OP_INS_BEFORE) || (op_t'(op) == OP_INS_AFTER);

	always_comb begin
		if (limit_q == ZERO_W) begin
			lim = ONE_W;
		end else if (limit_q > NODES_W) begin
			lim = NODES_W;
		end else begin
			lim = limit_q;
		end
	end

	assign sptr_adv = (sptr_q >= lim) ? ONE_W : sptr_q + ONE_W;

	assign flags.is_ins = (op_q == OP_INS_BEFORE) || (op_q == OP_INS_AFTER);
	assign flags.room   = (used_q < lim);
	assign flags.hit    = ~valid_q[sptr_q];
	assign flags.last   = (cnt_q == ONE_W);

	// link memory write ports
	always_comb begin
		nxt_we = 1'b0;
		nxt_wa = nw_q;
		nxt_wd = ZERO_W;
		prv_we = 1'b0;
		prv_wa = nw_q;
		prv_wd = ZERO_W;
		if (cmd.link1) begin
			nxt_we = 1'b1;
			prv_we = 1'b1;
			if (c == ZERO_W) begin
				if (head_q != ZERO_W) begin
					if (ins_front) begin
						nxt_wd = head_q;
					end else begin
						prv_wd = tail_q;
					end
				end
			end else if (ins_front) begin
				nxt_wd = c;
				prv_wd = p;
			end else begin
				nxt_wd = n;
				prv_wd = c;
			end
		end else if (cmd.link2) begin
			nxt_wd = nw_q;
			prv_wd = nw_q;
			if (c == ZERO_W) begin
				if (head_q != ZERO_W) begin
					if (ins_front) begin
						prv_we = 1'b1;
						prv_wa = head_q;
					end else begin
						nxt_we = 1'b1;
						nxt_wa = tail_q;
					end
				end
			end else if (ins_front) begin
				prv_we = 1'b1;
				prv_wa = c;
				nxt_we = (p != ZERO_W);
				nxt_wa = p;
			end else begin
				nxt_we = 1'b1;
				nxt_wa = c;
				prv_we = (n != ZERO_W);
				prv_wa = n;
			end
		end else if (cmd.exec && op_q == OP_REMOVE && c != ZERO_W) begin
			// unlink the node under the cursor
			nxt_we = (p != ZERO_W);
			nxt_wa = p;
			nxt_wd = n;
			prv_we = (n != ZERO_W);
			prv_wa = n;
			prv_wd = p;
		end
	end

	// result and new cursor of a non-insert request
	always_comb begin
		cur_x  = c;
		st_x   = ST_SUCCESS;
		dout_x = '0;
		case (op_q)
			OP_REMOVE, OP_READ: begin
				if (c == ZERO_W) begin
					st_x = ST_NO_CUR;
				end else begin
					dout_x = pay_rd_q;
					if (op_q == OP_REMOVE) begin
						cur_x = (n != ZERO_W) ? n : p;
					end
				end
			end
			OP_FORWARD: begin
				cur_x = (c == ZERO_W) ? head_q : n;
				if (cur_x == ZERO_W) st_x = ST_END;
			end
			OP_BACKWARD: begin
				cur_x = (c == ZERO_W) ? tail_q : p;
				if (cur_x == ZERO_W) st_x = ST_START;
			end
			OP_TO_HEAD: begin
				cur_x = head_q;
				if (cur_x == ZERO_W) st_x = ST_EMPTY;
			end
			OP_TO_TAIL: begin
				cur_x = tail_q;
				if (cur_x == ZERO_W) st_x = ST_EMPTY;
			end
			default: begin
				cur_x = c;
			end
		endcase
		idx_x = cur_x;
	end

	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (cmd.link2) pay_mem[nw_q] <= data_q;
		if (cmd.accept) begin
			nxt_rd_q <= nxt_mem[cur_q];
			prv_rd_q <= prv_mem[cur_q];
			pay_rd_q <= pay_mem[cur_q];
			op_q     <= op_t'(op);
			data_q   <= data_in;
			cnt_q    <= lim;
		end
		if (cmd.search) begin
			cnt_q <= cnt_q - ONE_W;
			if (flags.hit) nw_q <= sptr_q;
		end
		if (cmd.exec) begin
			status_q <= st_x;
			idx_q    <= idx_x;
			dout_q   <= dout_x;
		end else if (cmd.full) begin
			status_q <= ST_FULL;
			idx_q    <= c;
			dout_q   <= '0;
		end else if (cmd.link2) begin
			status_q <= ST_SUCCESS;
			idx_q    <= nw_q;
			dout_q   <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= ZERO_W;
			tail_q  <= ZERO_W;
			cur_q   <= ZERO_W;
			used_q  <= ZERO_W;
			sptr_q  <= ONE_W;
			limit_q <= NODES_W;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec | cmd.full | cmd.link2;
			if (cfg_we) limit_q <= cfg_wdata;
			if (cmd.accept && in_ins && used_q < lim &&
			    (sptr_q == ZERO_W || sptr_q > lim)) begin
				sptr_q <= ONE_W;
			end
			if (cmd.search) sptr_q <= sptr_adv;
			if (cmd.link2) begin
				valid_q[nw_q] <= 1'b1;
				used_q        <= used_q + ONE_W;
				if (c == ZERO_W) begin
					cur_q <= nw_q;
					if (head_q == ZERO_W) begin
						head_q <= nw_q;
						tail_q <= nw_q;
					end else if (ins_front) begin
						head_q <= nw_q;
					end else begin
						tail_q <= nw_q;
					end
				end else if (ins_front && p == ZERO_W) begin
					head_q <= nw_q;
				end else if (!ins_front && n == ZERO_W) begin
					tail_q <= nw_q;
				end
			end
			if (cmd.exec) begin
				cur_q <= cur_x;
				if (op_q == OP_REMOVE && c != ZERO_W) begin
					if (p == ZERO_W) head_q <= n;
					if (n == ZERO_W) tail_q <= p;
					valid_q[c] <= 1'b0;
					used_q     <= used_q - ONE_W;
				end
			end
		end
	end

	assign status     = status_q;
	assign node_index = idx_q;
	assign data_out   = dout_q;
	assign done       = done_q;

endmodule

@@ rtl/idll_ctrl.sv @@
// Controller: sequences fetch, free-slot search and link writes for each request.
module idll_ctrl import idll_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  idll_flags_t flags,
	output idll_cmd_t   cmd,
	output logic        busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_SEARCH,
		S_LINK1,
		S_LINK2
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_FETCH;
				end
			end
			S_FETCH: begin
				if (!flags.is_ins) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end else if (!flags.room) begin
					cmd.full = 1'b1;
					state_d  = S_IDLE;
				end else begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				if (flags.hit) begin
					state_d = S_LINK1;
				end else if (flags.last) begin
					cmd.full = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_LINK1: begin
				cmd.link1 = 1'b1;
				state_d   = S_LINK2;
			end
			S_LINK2: begin
				cmd.link2 = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

@@ rtl/indexed_doubly_linked_list_cursor.sv @@
// Top level of the indexed doubly linked list with one cursor.
// Usage: drive op and data_in with start high; the request is taken at a rising
//   edge where busy is low, and busy stays high until the request is done.
//   Each request yields one result on status, node_index and data_out, shown
//   for exactly one cycle with done high. The receiver cannot stall: sample the
//   result on that cycle. busy drops in the cycle done rises, so the next
//   request can be taken at the edge that ends the result cycle.
// Sequence: remove, read, step and jump finish from the fetch state. Insert
//   adds a round-robin free-slot search that examines between 1 and limit
//   slots, one valid bit per cycle; the LINK1 and LINK2 states then write the
//   new node's links and patch its neighbors, since each link memory has one
//   write port. A full list answers from the fetch state without a search, an
//   exhausted search after examining limit slots.
// Configuration: cfg_we/cfg_wdata write the node limit; write only while busy
//   is low and no result is pending.
// Reset: arst_n clears the list: empty, null cursor, search pointer at slot 1,
//   limit at the built capacity. Link and payload memories are not cleared.
module indexed_doubly_linked_list_cursor import idll_pkg::*; #(
	parameter int NODES        = NODES_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
	localparam int IW          = $clog2(NODES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              op,
	input  logic [PAYLOAD_BITS-1:0] data_in,
	input  logic                    cfg_we,
	input  logic [IW-1:0]           cfg_wdata,
	output logic                    done,
	output logic [STATUS_W-1:0]     status,
	output logic [IW-1:0]           node_index,
	output logic [PAYLOAD_BITS-1:0] data_out
);

	idll_cmd_t   cmd;
	idll_flags_t flags;

	// sequence each request: fetch, search, link, finish
	idll_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy)
	);

	// hold the list state and drive the result register
	idll_dpath #(
		.NODES        (NODES),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.op         (op),
		.data_in    (data_in),
		.cmd        (cmd),
		.flags      (flags),
		.status     (status),
		.node_index (node_index),
		.data_out   (data_out),
		.done       (done)
	);

endmodule

@@ sim/indexed_doubly_linked_list_cursor_test.sv @@
// Testbench for the indexed doubly linked list cursor: directed and random commands against a list model.
module indexed_doubly_linked_list_cursor_test;
	import idll_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N  = NODES_DEF;
	localparam int IW = $clog2(N + 1);

	// One expected answer per accepted request.
	typedef struct {
		status_t         st;
		logic [IW-1:0]   idx;
		logic [31:0]     dout;
	} answer_t;

	// Holds a private copy of the list and the queue of answers still due.
	class list_scoreboard;
		int            nxt [N+1];
		int            prv [N+1];
		bit            valid [N+1];
		logic [31:0]   pay [N+1];
		int            head, tail, cur, count, srch;
		int            limit_reg;
		answer_t       due [$];
		int            errors;

		function void clear();
			for (int i = 0; i <= N; i++) begin
				nxt[i] = 0; prv[i] = 0; valid[i] = 1'b0; pay[i] = '0;
			end
			head = 0; tail = 0; cur = 0; count = 0; srch = 1;
			limit_reg = N; errors = 0;
		endfunction

		function int eff_limit();
			int v;
			v = limit_reg;
			if (v == 0) v = 1;
			if (v > N) v = N;
			return v;
		endfunction

		// Round-robin free-slot search; 0 when nothing free.
		function int grab_slot(int lim);
			int found;
			found = 0;
			if (srch < 1 || srch > lim) srch = 1;
			for (int n = lim; n > 0 && found == 0; n--) begin
				if (!valid[srch]) found = srch;
				srch = (srch >= lim) ? 1 : srch + 1;
			end
			return found;
		endfunction

		// Apply one accepted request and queue its answer.
		function void note_request(op_t op, logic [31:0] din);
			answer_t a;
			int c, nw, lim, p, n;
			a.st = ST_SUCCESS;
			a.dout = '0;
			c = cur;
			if (op == OP_INS_BEFORE || op == OP_INS_AFTER) begin
				lim = eff_limit();
				nw = 0;
				if (count < lim) nw = grab_slot(lim);
				if (nw == 0) begin
					a.st = ST_FULL;
					a.idx = IW'(c);
				end else begin
					valid[nw] = 1'b1;
					pay[nw] = din;
					if (c == 0) begin
						if (head == 0) begin
							nxt[nw] = 0; prv[nw] = 0; head = nw; tail = nw;
						end else if (op == OP_INS_BEFORE) begin
							prv[head] = nw; nxt[nw] = head; prv[nw] = 0; head = nw;
						end else begin
							nxt[tail] = nw; prv[nw] = tail; nxt[nw] = 0; tail = nw;
						end
						cur = nw;
					end else if (op == OP_INS_BEFORE) begin
						p = prv[c];
						if (p != 0) nxt[p] = nw;
						else head = nw;
						prv[nw] = p; nxt[nw] = c; prv[c] = nw;
					end else begin
						n = nxt[c];
						if (n != 0) prv[n] = nw;
						else tail = nw;
						nxt[nw] = n; prv[nw] = c; nxt[c] = nw;
					end
					count = count + 1;
					a.idx = IW'(nw);
				end
			end else if (op == OP_REMOVE || op == OP_READ) begin
				if (c == 0) begin
					a.st = ST_NO_CUR;
				end else begin
					a.dout = pay[c];
					if (op == OP_REMOVE) begin
						p = prv[c];
						n = nxt[c];
						if (p != 0) nxt[p] = n;
						else head = n;
						if (n != 0) prv[n] = p;
						else tail = p;
						nxt[c] = 0; prv[c] = 0; valid[c] = 1'b0;
						count = count - 1;
						cur = (n != 0) ? n : p;
					end
				end
				a.idx = IW'(cur);
			end else if (op == OP_FORWARD) begin
				cur = (c == 0) ? head : nxt[c];
				if (cur == 0) a.st = ST_END;
				a.idx = IW'(cur);
			end else if (op == OP_BACKWARD) begin
				cur = (c == 0) ? tail : prv[c];
				if (cur == 0) a.st = ST_START;
				a.idx = IW'(cur);
			end else begin
				cur = (op == OP_TO_HEAD) ? head : tail;
				if (cur == 0) a.st = ST_EMPTY;
				a.idx = IW'(cur);
			end
			due.push_back(a);
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		// Compare one strobed result with the oldest answer due.
		task check_result(logic [2:0] st, logic [IW-1:0] idx, logic [31:0] dout);
			answer_t a;
			if (due.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			a = due.pop_front();
			if (st !== a.st)
				report($sformatf("status %0d, expected %0d", st, a.st));
			if (idx !== a.idx)
				report($sformatf("node_index %0d, expected %0d", idx, a.idx));
			if (dout !== a.dout)
				report($sformatf("data_out %h, expected %h", dout, a.dout));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [2:0]        op;
	logic [31:0]       data_in;
	logic              cfg_we;
	logic [IW-1:0]     cfg_wdata;
	logic              done;
	logic [2:0]        status;
	logic [IW-1:0]     node_index;
	logic [31:0]       data_out;

	list_scoreboard sb;

	indexed_doubly_linked_list_cursor u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.data_in    (data_in),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.status     (status),
		.node_index (node_index),
		.data_out   (data_out)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Check results at the edge that ends their strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, node_index, data_out);
	end

	// Drive one request; hold start until it is taken, then drop it
	// unless the caller keeps the burst going.
	int gap_left;

	task automatic send_request(op_t o, logic [31:0] d);
		start   <= 1'b1;
		op      <= o;
		data_in <= d;
		do @(posedge clk); while (busy);
		sb.note_request(o, d);
		if (gap_left > 0) begin
			start <= 1'b0;
			repeat (gap_left) @(posedge clk);
		end
	endtask

	// Drop start and wait until every answer has come, plus the longest
	// search tail, so that the block is idle.
	task automatic drain();
		int guard;
		start <= 1'b0;
		gap_left = 0;
		guard = 0;
		@(posedge clk);
		while (sb.due.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (N + 8) @(posedge clk);
	endtask

	task automatic write_limit(int v);
		cfg_we    <= 1'b1;
		cfg_wdata <= IW'(v);
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		sb.limit_reg = v & 'h1F;
	endtask

	// Pick a command; the mix favors inserts so the list grows and shrinks.
	function automatic op_t pick_op(int ins_weight);
		int r;
		r = $urandom_range(99);
		if (r < ins_weight) return ($urandom_range(1) != 0) ? OP_INS_AFTER : OP_INS_BEFORE;
		return op_t'($urandom_range(2, 7));
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(3))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	int burst;
	int limits [6] = '{16, 1, 3, 31, 0, 8};

	initial begin
		sb = new();
		sb.clear();
		arst_n    = 1'b0;
		start     = 1'b0;
		op        = OP_READ;
		data_in   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		gap_left  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty-list cases first, then build, walk and partly tear down.
		send_request(OP_READ, 0);
		send_request(OP_REMOVE, 0);
		send_request(OP_FORWARD, 0);
		send_request(OP_BACKWARD, 0);
		send_request(OP_TO_HEAD, 0);
		send_request(OP_TO_TAIL, 0);
		send_request(OP_INS_AFTER, 32'hFFFF_FFFF);
		send_request(OP_INS_BEFORE, 32'h0);
		send_request(OP_INS_AFTER, 32'hA5A5_5A5A);
		send_request(OP_FORWARD, 0);
		send_request(OP_FORWARD, 0);
		send_request(OP_FORWARD, 0);
		send_request(OP_INS_BEFORE, 32'h1234_5678);
		send_request(OP_INS_AFTER, 32'h8765_4321);
		send_request(OP_BACKWARD, 0);
		send_request(OP_BACKWARD, 0);
		send_request(OP_TO_TAIL, 0);
		send_request(OP_READ, 0);
		send_request(OP_REMOVE, 0);
		send_request(OP_TO_HEAD, 0);
		send_request(OP_REMOVE, 0);
		send_request(OP_REMOVE, 0);
		send_request(OP_READ, 0);
		drain();

		// Random phases, one per limit setting, extremes included. Lowering
		// the limit leaves nodes above it in the list on purpose.
		foreach (limits[k]) begin
			write_limit(limits[k]);
			for (int i = 0; i < 100; ) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && i < 100; b++, i++) begin
					gap_left = (b == burst - 1) ? $urandom_range(1, 6) : 0;
					if ($urandom_range(9) == 0) gap_left = 0;
					send_request(pick_op((k % 2 == 0) ? 45 : 30), rand_word());
				end
				// Hold off now and then until the block has answered everything.
				if ($urandom_range(15) == 0) drain();
			end
			drain();
		end

		if (sb.errors == 0 && sb.due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
